[rtl/sirt_pkg.sv]
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types, constants and helpers for the signed integer to radix text
// block: register map, command and status groups, symbol lookup.
// ----------------------------------------------------------------------------
package sirt_pkg;

	// Widths fixed by the register map and the fields
	localparam int VAL_W     = 32;
	localparam int RADIX_W   = 5;
	localparam int DIGIT_W   = 4;
	localparam int SYM_W     = 8;
	localparam int ALPH_W    = 64;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 5;
	localparam int NUM_SYM   = 16;
	localparam int DIG_DEPTH = 32;
	localparam int DIG_IDX_W = 5;
	localparam int DIG_CNT_W = 6;
	localparam int STEP_W    = 3;

	localparam int MAX_RADIX_DEF = 16;

	// Sign characters
	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

	// Register indexes (byte address = 8 * index)
	localparam logic [1:0] REG_RADIX  = 2'd0;
	localparam logic [1:0] REG_ALPH_L = 2'd1;
	localparam logic [1:0] REG_ALPH_H = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;        // request accepted: latch magnitude, clear counters
		logic chk_inc;     // advance alphabet check index
		logic div_step;    // one 4-bit step of the digit divider
		logic push_sign;   // load '-' into the output register
		logic rd_issue;    // read digit buffer at current index
		logic push_digit;  // load digit symbol into the output register
	} sirt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic cfg_bad;   // radix out of range
		logic sym_bad;   // current symbol is a sign or repeats later
		logic chk_last;  // current symbol is the last one in use
		logic div_last;  // this divider step finishes a digit
		logic quo_zero;  // quotient after this digit is zero
		logic neg;       // value was negative
		logic rd_first;  // read index points at the least significant digit
		logic out_free;  // output register can take a symbol this cycle
	} sirt_sts_t;

	// Symbol of a digit value
	function automatic logic [SYM_W-1:0] sym_of(
		input logic [ALPH_W-1:0]  lo,
		input logic [ALPH_W-1:0]  hi,
		input logic [DIGIT_W-1:0] d
	);
		logic [ALPH_W-1:0] w;
		w = d[3] ? hi : lo;
		return w[{d[2:0], 3'b000} +: SYM_W];
	endfunction

endpackage

[rtl/sirt_regs.sv]
// ----------------------------------------------------------------------------
// sirt_regs
// Configuration registers behind an APB-style port: radix and the two
// alphabet words. Always ready; reads return the stored values.
// ----------------------------------------------------------------------------
module sirt_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sirt_pkg::ADDR_W-1:0]    paddr,
	input  logic [sirt_pkg::DATA_W-1:0]    pwdata,
	output logic [sirt_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output logic [sirt_pkg::RADIX_W-1:0]   radix,
	output logic [sirt_pkg::ALPH_W-1:0]    alph_lo,
	output logic [sirt_pkg::ALPH_W-1:0]    alph_hi
);
	import sirt_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic [ALPH_W-1:0]  alph_lo_q;
	logic [ALPH_W-1:0]  alph_hi_q;
	logic [1:0]         reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q   <= '0;
			alph_lo_q <= '0;
			alph_hi_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RADIX:  radix_q   <= pwdata[RADIX_W-1:0];
				REG_ALPH_L: alph_lo_q <= pwdata;
				REG_ALPH_H: alph_hi_q <= pwdata;
				default:    ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_RADIX:  prdata = {{(DATA_W-RADIX_W){1'b0}}, radix_q};
			REG_ALPH_L: prdata = alph_lo_q;
			REG_ALPH_H: prdata = alph_hi_q;
			default:    prdata = '0;
		endcase
	end

	assign radix   = radix_q;
	assign alph_lo = alph_lo_q;
	assign alph_hi = alph_hi_q;

endmodule

[rtl/sirt_dp.sv]
// ----------------------------------------------------------------------------
// sirt_dp
// Datapath: alphabet checker, 4-bit-per-cycle divider by the radix, digit
// buffer, and the output register with its valid/stall handshake.
// ----------------------------------------------------------------------------
module sirt_dp #(
	parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sirt_pkg::sirt_cmd_t            cmd,
	output sirt_pkg::sirt_sts_t            sts,
	input  logic signed [sirt_pkg::VAL_W-1:0] value,
	input  logic [sirt_pkg::RADIX_W-1:0]   radix,
	input  logic [sirt_pkg::ALPH_W-1:0]    alph_lo,
	input  logic [sirt_pkg::ALPH_W-1:0]    alph_hi,
	output logic [sirt_pkg::SYM_W-1:0]     symbol,
	output logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall
);
	import sirt_pkg::*;

	logic [VAL_W-1:0]     dvd_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIG_CNT_W-1:0] cnt_q;
	logic [DIG_IDX_W-1:0] rd_idx_q;
	logic [DIGIT_W-1:0]   rd_q;
	logic [DIGIT_W-1:0]   chk_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic [SYM_W-1:0]     sym_q;
	logic                 last_q;
	logic [DIGIT_W-1:0]   dig_mem [DIG_DEPTH];

	logic [VAL_W-1:0]     mag;
	logic [VAL_W-1:0]     dvd_nx;
	logic [DIGIT_W-1:0]   rem_nx;
	logic [SYM_W-1:0]     chk_sym;
	logic                 dup;
	logic                 out_free;

	// Magnitude of the incoming value
	assign mag = value[VAL_W-1] ? (~$unsigned(value) + 32'd1) : $unsigned(value);

	// Alphabet check for the symbol at chk_q against all later symbols in use
	always_comb begin
		chk_sym = sym_of(alph_lo, alph_hi, chk_q);
		dup     = 1'b0;
		for (int j = 0; j < NUM_SYM; j++) begin
			if ((5'(j) > {1'b0, chk_q}) && (5'(j) < radix) &&
			    (sym_of(alph_lo, alph_hi, 4'(j)) == chk_sym))
				dup = 1'b1;
		end
	end

	// Four restoring division steps per cycle
	always_comb begin
		logic [RADIX_W-1:0] r;
		logic [RADIX_W-1:0] t;
		logic [3:0]         qb;
		r  = {1'b0, rem_q};
		qb = '0;
		for (int b = 3; b >= 0; b--) begin
			t = {r[3:0], dvd_q[28+b]};
			if (t >= radix) begin
				t     = t - radix;
				qb[b] = 1'b1;
			end
			r = t;
		end
		rem_nx = r[DIGIT_W-1:0];
		dvd_nx = {dvd_q[VAL_W-5:0], qb};
	end

	assign out_free = !out_valid_q || !out_stall;

	// Status to the controller
	always_comb begin
		sts.cfg_bad  = (radix < 5'd2) || (radix > RADIX_W'(MAX_RADIX));
		sts.sym_bad  = dup || (chk_sym == SYM_PLUS) || (chk_sym == SYM_MINUS);
		sts.chk_last = ({1'b0, chk_q} == (radix - 5'd1));
		sts.div_last = (step_q == '1);
		sts.quo_zero = (dvd_nx == '0);
		sts.neg      = neg_q;
		sts.rd_first = (rd_idx_q == '0);
		sts.out_free = out_free;
	end

	// Divider, counters and check index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			chk_q    <= '0;
			neg_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
				cnt_q  <= '0;
				chk_q  <= '0;
				neg_q  <= value[VAL_W-1];
			end
			if (cmd.chk_inc)
				chk_q <= chk_q + 4'd1;
			if (cmd.div_step) begin
				step_q <= step_q + 3'd1;
				if (sts.div_last) begin
					cnt_q    <= cnt_q + 6'd1;
					rd_idx_q <= cnt_q[DIG_IDX_W-1:0];
				end
			end
			if (cmd.push_digit && !sts.rd_first)
				rd_idx_q <= rd_idx_q - 5'd1;
		end
	end

	// Dividend and partial remainder
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= mag;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_nx;
			rem_q <= sts.div_last ? '0 : rem_nx;
		end
	end

	// Digit buffer, least significant digit first
	always_ff @(posedge clk) begin
		if (cmd.div_step && sts.div_last)
			dig_mem[cnt_q[DIG_IDX_W-1:0]] <= rem_nx;
		if (cmd.rd_issue)
			rd_q <= dig_mem[rd_idx_q];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push_sign || cmd.push_digit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push_sign) begin
			sym_q  <= SYM_MINUS;
			last_q <= 1'b0;
		end else if (cmd.push_digit) begin
			sym_q  <= sym_of(alph_lo, alph_hi, rd_q);
			last_q <= sts.rd_first;
		end
	end

	assign symbol    = sym_q;
	assign last      = last_q;
	assign out_valid = out_valid_q;

	// A symbol is only loaded when the output register is free
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_sign || cmd.push_digit) |-> out_free)
		else $error("symbol pushed over a pending result");

	// Digit count stays within the buffer
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(DIG_DEPTH))
		else $error("digit count overflow");

	// Partial remainder is always below the radix while dividing
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> ({1'b0, rem_q} < radix))
		else $error("remainder not below radix");

endmodule

[rtl/sirt_ctrl.sv]
// ----------------------------------------------------------------------------
// sirt_ctrl
// Controller: sequences alphabet check, digit division and symbol output
// for one request at a time.
// ----------------------------------------------------------------------------
module sirt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output sirt_pkg::sirt_cmd_t cmd,
	input  sirt_pkg::sirt_sts_t sts
);
	import sirt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_SIGN  = 6'b001000,
		ST_LOAD  = 6'b010000,
		ST_PUSH  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.cfg_bad || sts.sym_bad)
					state_nx = ST_IDLE;
				else if (sts.chk_last)
					state_nx = ST_DIV;
				else
					cmd.chk_inc = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last && sts.quo_zero)
					state_nx = sts.neg ? ST_SIGN : ST_LOAD;
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.push_sign = 1'b1;
					state_nx      = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.rd_issue = 1'b1;
				state_nx     = ST_PUSH;
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push_digit = 1'b1;
					state_nx       = sts.rd_first ? ST_IDLE : ST_LOAD;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// Sign goes out before any digit, and only for negative values
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_sign |-> sts.neg)
		else $error("sign pushed for non-negative value");

	// The final digit returns the controller to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_digit && sts.rd_first) |=> (state_q == ST_IDLE))
		else $error("controller busy after final symbol");

	// A request is taken only in idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !in_stall)
		else $error("request loaded while busy");

endmodule

[rtl/signed_integer_to_radix_text.sv]
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// One request at a time: an accept step, the alphabet check over the symbols in use,
// a division per digit (4 quotient bits a cycle), a buffer read and a push per digit
// symbol, a sign push for negative values, plus stalls. Worst case: radix 2, most
// negative value. A rejected setting ends after the check. Reset clears config to 0.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text #(
	parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sirt_pkg::ADDR_W-1:0]        paddr,
	input  logic [sirt_pkg::DATA_W-1:0]        pwdata,
	output logic [sirt_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [sirt_pkg::VAL_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sirt_pkg::SYM_W-1:0]         symbol,
	output logic                               last
);
	import sirt_pkg::*;

	logic [RADIX_W-1:0] radix;
	logic [ALPH_W-1:0]  alph_lo;
	logic [ALPH_W-1:0]  alph_hi;
	sirt_cmd_t          cmd;
	sirt_sts_t          sts;

	// Configuration registers
	sirt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.radix   (radix),
		.alph_lo (alph_lo),
		.alph_hi (alph_hi)
	);

	// Sequencer
	sirt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath
	sirt_dp #(
		.MAX_RADIX (MAX_RADIX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.radix     (radix),
		.alph_lo   (alph_lo),
		.alph_hi   (alph_hi),
		.symbol    (symbol),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule
